@@ sv/bclc_pkg.sv @@
// Package for the block cache tag and replacement controller.
// Holds widths, request kinds and the controller-to-datapath command structs.
// No dependencies.
package bclc_pkg;

  localparam int LinesDefault   = 64;
  localparam int DevicesDefault = 64;
  localparam int MaxOut         = 64;
  localparam int KindW          = 3;
  localparam int DevW           = 6;
  localparam int AddrW          = 64;
  localparam int StampW         = 64;
  localparam int LineOutW       = 6;

  localparam logic [KindW-1:0] KIND_READ  = 3'd0;
  localparam logic [KindW-1:0] KIND_WRITE = 3'd1;
  localparam logic [KindW-1:0] KIND_FLUSH = 3'd2;
  localparam logic [KindW-1:0] KIND_SYNCA = 3'd3;
  localparam logic [KindW-1:0] KIND_SYNCD = 3'd4;

  typedef struct packed {
    logic start;
    logic step;
    logic commit;
    logic sync_clean;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic hit_found;
    logic sync_hit;
  } dp_sts_t;

endpackage

@@ sv/bclc_datapath.sv @@
// Datapath of the block cache controller: tag registers, line scan and results.
// Depends on bclc_pkg; driven by bclc_ctrl through command and status structs.
module bclc_datapath #(
  parameter int LINES   = bclc_pkg::LinesDefault,
  parameter int DEVICES = bclc_pkg::DevicesDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bclc_pkg::KindW-1:0]    kind,
  input  logic [bclc_pkg::DevW-1:0]     device,
  input  logic [bclc_pkg::AddrW-1:0]    block_addr,
  input  logic                          load,
  input  bclc_pkg::dp_cmd_t             cmd,
  output bclc_pkg::dp_sts_t             sts,
  output logic                          res_hit,
  output logic [bclc_pkg::LineOutW-1:0] res_line,
  output logic                          res_wb,
  output logic [bclc_pkg::DevW-1:0]     res_vdev,
  output logic [bclc_pkg::AddrW-1:0]    res_vaddr,
  output logic                          res_fill
);

  localparam int IdxW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CntW = $clog2(LINES + 1);

  logic [bclc_pkg::DevW-1:0]   tdev_r [LINES];
  logic [bclc_pkg::AddrW-1:0]  taddr_r [LINES];
  logic [bclc_pkg::StampW-1:0] stamp_r [LINES];
  logic [LINES-1:0]            valid_r, dirty_r;
  logic [bclc_pkg::StampW-1:0] clock_r;

  logic [bclc_pkg::KindW-1:0]  kind_r;
  logic [bclc_pkg::DevW-1:0]   dev_r;
  logic [bclc_pkg::AddrW-1:0]  addr_r;
  logic [CntW-1:0]             idx_r;
  logic [IdxW-1:0]             cur;
  logic                        fetch;

  logic                        qv_r;
  logic [IdxW-1:0]             qidx_r;
  logic [bclc_pkg::DevW-1:0]   qdev_r;
  logic [bclc_pkg::AddrW-1:0]  qaddr_r;
  logic [bclc_pkg::StampW-1:0] qstamp_r;

  logic                        hit_r, inv_r, cln_r, any_r;
  logic [IdxW-1:0]             hidx_r, iidx_r, cidx_r, aidx_r;
  logic [bclc_pkg::StampW-1:0] cst_r, ast_r;
  logic [bclc_pkg::DevW-1:0]   adev_r;
  logic [bclc_pkg::AddrW-1:0]  aaddr_r;

  logic                        cur_match, cur_sync;
  logic [IdxW-1:0]             vic;
  logic                        is_write;

  // The tag store is read one line per cycle, while the controller steps, into registers; the scan compares
  // the registered line while the next one is fetched.
  assign cur       = idx_r[IdxW-1:0];
  assign fetch     = (idx_r < CntW'(LINES));
  assign cur_match = qv_r && valid_r[qidx_r] && qdev_r == dev_r && qaddr_r == addr_r;
  assign cur_sync  = qv_r && valid_r[qidx_r] && dirty_r[qidx_r]
                     && (kind_r == bclc_pkg::KIND_SYNCA || qdev_r == dev_r);
  assign sts.scan_end  = qv_r && (qidx_r == IdxW'(LINES - 1));
  assign sts.hit_found = hit_r;
  assign sts.sync_hit  = cur_sync;
  assign is_write = (kind_r == bclc_pkg::KIND_WRITE);
  assign vic = inv_r ? iidx_r : (cln_r ? cidx_r : aidx_r);

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind;
      dev_r  <= device;
      addr_r <= block_addr;
    end
    if (cmd.start) begin
      idx_r <= '0;
      qv_r  <= 1'b0;
      hit_r <= 1'b0;
      inv_r <= 1'b0;
      cln_r <= 1'b0;
      any_r <= 1'b0;
    end else if (cmd.step) begin
      qv_r <= fetch;
      if (fetch) begin
        idx_r    <= idx_r + CntW'(1);
        qidx_r   <= cur;
        qdev_r   <= tdev_r[cur];
        qaddr_r  <= taddr_r[cur];
        qstamp_r <= stamp_r[cur];
      end
      if (qv_r) begin
        if (cur_match && !hit_r) begin
          hit_r  <= 1'b1;
          hidx_r <= qidx_r;
        end
        if (!valid_r[qidx_r] && !inv_r) begin
          inv_r  <= 1'b1;
          iidx_r <= qidx_r;
        end
        if (!any_r || qstamp_r < ast_r) begin
          any_r   <= 1'b1;
          aidx_r  <= qidx_r;
          ast_r   <= qstamp_r;
          adev_r  <= qdev_r;
          aaddr_r <= qaddr_r;
        end
        if (!dirty_r[qidx_r] && (!cln_r || qstamp_r < cst_r)) begin
          cln_r  <= 1'b1;
          cidx_r <= qidx_r;
          cst_r  <= qstamp_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      clock_r <= '0;
    end else if (cmd.commit) begin
      if (kind_r == bclc_pkg::KIND_FLUSH) begin
        if (hit_r) dirty_r[hidx_r] <= 1'b0;
      end else if (hit_r) begin
        clock_r         <= clock_r + 1'b1;
        stamp_r[hidx_r] <= clock_r + 1'b1;
        if (is_write) dirty_r[hidx_r] <= 1'b1;
      end else begin
        clock_r      <= clock_r + 1'b1;
        stamp_r[vic] <= clock_r + 1'b1;
        tdev_r[vic]  <= dev_r;
        taddr_r[vic] <= addr_r;
        valid_r[vic] <= 1'b1;
        dirty_r[vic] <= is_write;
      end
    end else if (cmd.sync_clean) begin
      dirty_r[qidx_r] <= 1'b0;
    end
  end

  // Result fields for the current command; the controller registers them.
  // A dirty victim can only be the oldest line, whose tag is kept by the scan.
  always_comb begin
    res_hit   = 1'b0;
    res_line  = '0;
    res_wb    = 1'b0;
    res_vdev  = '0;
    res_vaddr = '0;
    res_fill  = 1'b0;
    if (cmd.sync_clean) begin
      res_line  = bclc_pkg::LineOutW'(qidx_r);
      res_wb    = 1'b1;
      res_vdev  = qdev_r;
      res_vaddr = qaddr_r;
    end else if (kind_r == bclc_pkg::KIND_FLUSH) begin
      if (hit_r) begin
        res_hit  = 1'b1;
        res_line = bclc_pkg::LineOutW'(hidx_r);
        if (dirty_r[hidx_r]) begin
          res_wb    = 1'b1;
          res_vdev  = dev_r;
          res_vaddr = addr_r;
        end
      end
    end else if (hit_r) begin
      res_hit  = 1'b1;
      res_line = bclc_pkg::LineOutW'(hidx_r);
    end else begin
      res_line = bclc_pkg::LineOutW'(vic);
      res_fill = !is_write;
      if (valid_r[vic] && dirty_r[vic]) begin
        res_wb    = 1'b1;
        res_vdev  = adev_r;
        res_vaddr = aaddr_r;
      end
    end
  end

endmodule

@@ sv/bclc_ctrl.sv @@
// Controller state machine of the block cache controller.
// Depends on bclc_pkg; steers bclc_datapath and owns the output register.
module bclc_ctrl #(
  parameter int DEVICES = bclc_pkg::DevicesDefault
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [bclc_pkg::KindW-1:0] kind,
  input  logic [bclc_pkg::DevW-1:0]  device,
  input  logic                       request_end,
  output logic                       load,
  output bclc_pkg::dp_cmd_t          cmd,
  input  bclc_pkg::dp_sts_t          sts,
  input  logic                       res_hit,
  input  logic [bclc_pkg::LineOutW-1:0] res_line,
  input  logic                       res_wb,
  input  logic [bclc_pkg::DevW-1:0]  res_vdev,
  input  logic [bclc_pkg::AddrW-1:0] res_vaddr,
  input  logic                       res_fill,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [79:0]                out_tdata,
  output logic [1:0]                 out_tuser
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DONE = 3'd2;
  localparam logic [2:0] S_SYNC = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic        ovalid_r;
  logic [79:0] odata_r;
  logic [1:0]  ouser_r;
  logic        done_r, any_r, any_nxt;
  logic        is_sync, bad, obusy, push, push_empty;

  assign is_sync = kind == bclc_pkg::KIND_SYNCA || kind == bclc_pkg::KIND_SYNCD;
  assign bad = kind > bclc_pkg::KIND_SYNCD || 32'(device) >= DEVICES;
  assign obusy = ovalid_r && !out_tready;
  assign in_tready = (state_r == S_IDLE) && !obusy;
  assign load = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    push           = 1'b0;
    push_empty     = 1'b0;
    any_nxt        = any_r;
    unique case (state_r)
      S_IDLE: begin
        if (load) begin
          if (bad) begin
            push = 1'b1;
            push_empty = 1'b1;
          end else begin
            state_nxt = is_sync ? S_SYNC : S_SCAN;
            any_nxt = 1'b0;
          end
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_end) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!obusy) begin
          push = 1'b1;
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SYNC: begin
        if (!obusy) begin
          cmd.step = 1'b1;
          if (sts.sync_hit) begin
            cmd.sync_clean = 1'b1;
            push = 1'b1;
            any_nxt = 1'b1;
          end
          if (sts.scan_end) state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        // The last sync result is sent once the scan proves no dirty line follows.
        if (!obusy) begin
          push = 1'b1;
          push_empty = !any_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.start = load;
  end

  // A sync result is held back one line so its last flag is known before sending.
  logic        pend_r;
  logic [79:0] pdata_r;
  logic [79:0] rdata;
  assign rdata = {1'b0, res_fill, res_vaddr, res_vdev, res_wb, res_line, res_hit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      pend_r   <= 1'b0;
      any_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      any_r   <= any_nxt;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      if (push && state_r == S_SYNC) begin
        pend_r  <= 1'b1;
        pdata_r <= rdata;
        if (pend_r) begin
          ovalid_r <= 1'b1;
          odata_r  <= pdata_r;
          ouser_r  <= {1'b0, done_r};
        end
      end else if (push) begin
        ovalid_r <= 1'b1;
        pend_r   <= 1'b0;
        ouser_r  <= {1'b1, load ? request_end : done_r};
        if (push_empty) odata_r <= '0;
        else if (pend_r) odata_r <= pdata_r;
        else odata_r <= rdata;
      end
    end
    if (load) done_r <= request_end;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule

@@ sv/block_cache_lru_controller_unit.sv @@
// Top level of the block cache tag and LRU replacement controller.
// Depends on bclc_pkg, bclc_datapath and bclc_ctrl.
//
// Channel  Direction  tdata fields (low bit up)                          tuser
// in_      slave      kind, device, block_addr, pad                      request_end
// out_     master     hit, line, writeback, victim_device, victim_addr,  request_done, last
//                     fill, pad
//
// A read, write or flush fetches the first line, then compares and ages one registered
// line of the tag store per cycle, then commits.
// A sync walks all lines the same way, holding while a result is stalled,
// and emits a write-back per dirty match.
// Reset clears valid and dirty bits and the access clock.
// A stalled result holds the sync walk; the next request waits until the result is taken.
module block_cache_lru_controller_unit #(
  parameter int LINES   = bclc_pkg::LinesDefault,
  parameter int DEVICES = bclc_pkg::DevicesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // kind, device, block_addr
  input  logic        in_tuser,   // request_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // hit, line, writeback, victim_device, victim_addr, fill
  output logic [1:0]  out_tuser   // request_done, last
);

  bclc_pkg::dp_cmd_t cmd;
  bclc_pkg::dp_sts_t sts;
  logic load, r_hit, r_wb, r_fill;
  logic [bclc_pkg::LineOutW-1:0] r_line;
  logic [bclc_pkg::DevW-1:0] r_vdev;
  logic [bclc_pkg::AddrW-1:0] r_vaddr;

  bclc_datapath #(.LINES(LINES), .DEVICES(DEVICES)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .kind(in_tdata[2:0]), .device(in_tdata[8:3]), .block_addr(in_tdata[72:9]),
    .load(load), .cmd(cmd), .sts(sts),
    .res_hit(r_hit), .res_line(r_line), .res_wb(r_wb), .res_vdev(r_vdev),
    .res_vaddr(r_vaddr), .res_fill(r_fill)
  );

  bclc_ctrl #(.DEVICES(DEVICES)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .kind(in_tdata[2:0]), .device(in_tdata[8:3]), .request_end(in_tuser),
    .load(load), .cmd(cmd), .sts(sts),
    .res_hit(r_hit), .res_line(r_line), .res_wb(r_wb), .res_vdev(r_vdev),
    .res_vaddr(r_vaddr), .res_fill(r_fill),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

@@ sim/bclc_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the block cache tag and LRU replacement controller.
// Watches the request and result channels, predicts results; depends on bclc_pkg.
module bclc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  localparam int NLines = 64;

  typedef struct packed {
    logic        hit;
    logic [5:0]  line;
    logic        writeback;
    logic [5:0]  vdev;
    logic [63:0] vaddr;
    logic        fill;
    logic        done;
    logic        last;
  } cache_result_t;

  logic [5:0]  tag_dev   [NLines];
  logic [63:0] tag_addr  [NLines];
  logic        valid     [NLines];
  logic        dirty     [NLines];
  logic [63:0] stamp     [NLines];
  logic [63:0] access_clk;
  cache_result_t expected_q[$];

  function automatic cache_result_t mk(logic h, int ln, logic wb, logic [5:0] d,
                                       logic [63:0] a, logic f, logic dn, logic l);
    cache_result_t r;
    r.hit = h; r.line = ln[5:0]; r.writeback = wb; r.vdev = d; r.vaddr = a;
    r.fill = f; r.done = dn; r.last = l;
    return r;
  endfunction

  task automatic predict_request(logic [2:0] kind, logic [5:0] dev, logic [63:0] addr,
                                 logic dn);
    int idx, victim, clean_i, any_i, n;
    logic wb;
    idx = -1;
    if (kind > bclc_pkg::KIND_SYNCD) begin
      expected_q.push_back(mk(0, 0, 0, 0, 0, 0, dn, 1));
      return;
    end
    if (kind != bclc_pkg::KIND_SYNCA && kind != bclc_pkg::KIND_SYNCD) begin
      for (int i = NLines - 1; i >= 0; i--)
        if (valid[i] && tag_dev[i] == dev && tag_addr[i] == addr) idx = i;
    end
    if (kind == bclc_pkg::KIND_READ || kind == bclc_pkg::KIND_WRITE) begin
      if (idx >= 0) begin
        access_clk++;
        stamp[idx] = access_clk;
        if (kind == bclc_pkg::KIND_WRITE) dirty[idx] = 1;
        expected_q.push_back(mk(1, idx, 0, 0, 0, 0, dn, 1));
        return;
      end
      victim = -1;
      for (int i = NLines - 1; i >= 0; i--)
        if (!valid[i]) victim = i;
      if (victim < 0) begin
        clean_i = -1; any_i = -1;
        for (int i = 0; i < NLines; i++) begin
          if (any_i < 0 || stamp[i] < stamp[any_i]) any_i = i;
          if (!dirty[i] && (clean_i < 0 || stamp[i] < stamp[clean_i])) clean_i = i;
        end
        victim = (clean_i >= 0) ? clean_i : any_i;
      end
      wb = valid[victim] && dirty[victim];
      expected_q.push_back(mk(0, victim, wb, wb ? tag_dev[victim] : 6'd0,
                              wb ? tag_addr[victim] : 64'd0,
                              kind == bclc_pkg::KIND_READ, dn, 1));
      tag_dev[victim] = dev;
      tag_addr[victim] = addr;
      valid[victim] = 1;
      dirty[victim] = (kind == bclc_pkg::KIND_WRITE);
      access_clk++;
      stamp[victim] = access_clk;
    end else if (kind == bclc_pkg::KIND_FLUSH) begin
      if (idx >= 0 && dirty[idx]) begin
        dirty[idx] = 0;
        expected_q.push_back(mk(1, idx, 1, tag_dev[idx], tag_addr[idx], 0, dn, 1));
      end else if (idx >= 0) begin
        expected_q.push_back(mk(1, idx, 0, 0, 0, 0, dn, 1));
      end else begin
        expected_q.push_back(mk(0, 0, 0, 0, 0, 0, dn, 1));
      end
    end else begin
      n = 0;
      for (int i = 0; i < NLines; i++) begin
        if (valid[i] && dirty[i] && (kind == bclc_pkg::KIND_SYNCA || tag_dev[i] == dev)) begin
          dirty[i] = 0;
          expected_q.push_back(mk(0, i, 1, tag_dev[i], tag_addr[i], 0, dn, 0));
          n++;
        end
      end
      if (n == 0) expected_q.push_back(mk(0, 0, 0, 0, 0, 0, dn, 1));
      else expected_q[$].last = 1;
    end
  endtask

  task automatic compare_result(cache_result_t got);
    cache_result_t w;
    if (expected_q.size() == 0) begin
      $error("result with no request outstanding: %h", got);
      fail_count++;
      return;
    end
    w = expected_q.pop_front();
    if (got.hit != w.hit) begin
      $error("hit: expected %0d, got %0d", w.hit, got.hit); fail_count++;
    end
    if (got.line != w.line) begin
      $error("line: expected %0d, got %0d", w.line, got.line); fail_count++;
    end
    if (got.writeback != w.writeback) begin
      $error("writeback: expected %0d, got %0d", w.writeback, got.writeback); fail_count++;
    end
    if (got.vdev != w.vdev) begin
      $error("victim_device: expected %0d, got %0d", w.vdev, got.vdev); fail_count++;
    end
    if (got.vaddr != w.vaddr) begin
      $error("victim_addr: expected %h, got %h", w.vaddr, got.vaddr); fail_count++;
    end
    if (got.fill != w.fill) begin
      $error("fill: expected %0d, got %0d", w.fill, got.fill); fail_count++;
    end
    if (got.done != w.done) begin
      $error("request_done: expected %0d, got %0d", w.done, got.done); fail_count++;
    end
    if (got.last != w.last) begin
      $error("last: expected %0d, got %0d", w.last, got.last); fail_count++;
    end
  endtask

  initial fail_count = 0;
  assign pending = expected_q.size();

  always @(posedge clk) begin
    cache_result_t got;
    if (!rst_n) begin
      expected_q.delete();
      access_clk = 0;
      for (int i = 0; i < NLines; i++) begin
        tag_dev[i] = 0; tag_addr[i] = 0; valid[i] = 0; dirty[i] = 0; stamp[i] = 0;
      end
    end else begin
      if (out_tvalid && out_tready) begin
        got.hit = out_tdata[0];
        got.line = out_tdata[6:1];
        got.writeback = out_tdata[7];
        got.vdev = out_tdata[13:8];
        got.vaddr = out_tdata[77:14];
        got.fill = out_tdata[78];
        got.done = out_tuser[0];
        got.last = out_tuser[1];
        compare_result(got);
      end
      if (in_tvalid && in_tready)
        predict_request(in_tdata[2:0], in_tdata[8:3], in_tdata[72:9], in_tuser);
    end
  end
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the block cache tag and LRU replacement controller.
// Drives requests and result stalls; depends on bclc_pkg and bclc_checker.
module tb_top;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [63:0] addr_pool[8];

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  block_cache_lru_controller_unit i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  bclc_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .fail_count, .pending
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // The valid flag stays up after an accepted request unless the sender idles
  // or the caller drops it.
  task automatic send_request(logic [2:0] kind, logic [5:0] dev, logic [63:0] addr,
                              logic req_end);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {7'd0, addr, dev, kind};
    in_tuser <= req_end;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random_request();
    int r;
    logic [2:0] kind;
    logic [5:0] dev;
    logic [63:0] addr;
    r = $urandom_range(99);
    if (r < 40) kind = bclc_pkg::KIND_READ;
    else if (r < 75) kind = bclc_pkg::KIND_WRITE;
    else if (r < 85) kind = bclc_pkg::KIND_FLUSH;
    else if (r < 90) kind = bclc_pkg::KIND_SYNCA;
    else if (r < 95) kind = bclc_pkg::KIND_SYNCD;
    else kind = 3'($urandom_range(7, 5));
    dev = 6'($urandom_range(3));
    if ($urandom_range(9) == 0) dev = 6'($urandom);
    addr = addr_pool[$urandom_range(7)] + 64'($urandom_range(60));
    if ($urandom_range(9) == 0) addr = {$urandom, $urandom};
    send_request(kind, dev, addr, 1'($urandom));
  endtask

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int guard;
    for (int i = 0; i < 8; i++) addr_pool[i] = {$urandom, $urandom};
    addr_pool[0] = 64'd0;
    addr_pool[1] = 64'hFFFF_FFFF_FFFF_FF00;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_request(bclc_pkg::KIND_READ, 6'd0, 64'd0, 0);
    send_request(bclc_pkg::KIND_WRITE, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    send_request(bclc_pkg::KIND_READ, 6'd0, 64'd0, 1);
    send_request(bclc_pkg::KIND_WRITE, 6'd0, 64'd0, 0);
    send_request(bclc_pkg::KIND_FLUSH, 6'd0, 64'd0, 1);
    send_request(bclc_pkg::KIND_FLUSH, 6'd0, 64'd0, 0);
    send_request(bclc_pkg::KIND_FLUSH, 6'd5, 64'h1234, 1);
    send_request(bclc_pkg::KIND_SYNCA, 6'd0, 64'd0, 1);
    send_request(bclc_pkg::KIND_WRITE, 6'd21, 64'hAAAA_5555_AAAA_5555, 0);
    send_request(bclc_pkg::KIND_WRITE, 6'd42, 64'h5555_AAAA_5555_AAAA, 1);
    send_request(bclc_pkg::KIND_SYNCD, 6'd21, 64'd7, 0);
    send_request(bclc_pkg::KIND_SYNCD, 6'd33, 64'd0, 1);
    send_request(bclc_pkg::KIND_SYNCA, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_request(3'd5, 6'd1, 64'd1, 1);
    send_request(3'd7, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    // Fill every line dirty, then miss to force dirty LRU eviction and a full sync.
    for (int i = 0; i < 66; i++) send_request(bclc_pkg::KIND_WRITE, 6'd2, 64'(i + 100), 1);
    for (int i = 0; i < 3; i++) send_request(bclc_pkg::KIND_READ, 6'd3, 64'(i), 0);
    send_request(bclc_pkg::KIND_SYNCA, 6'd0, 64'd0, 1);
    send_request(bclc_pkg::KIND_READ, 6'd4, 64'd9, 0);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 13 : 51) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 13 : 51) : 0;
      for (int k = 0; k < 21; k++) send_random_request();
      in_tvalid <= 0;
      while (pending != 0) @(posedge clk);
    end
    recv_stall_pct = 0;
    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
